@@ src/tdvi_pkg.sv @@
// tdvi_pkg: shared types, constants and the 16.16 multiply helper
// used by the lanes and the top level of the velocity integrator
// no dependencies
package tdvi_pkg;

  // number of vector components worked on side by side
  localparam int unsigned LANES = 3;

  // 1.0 in 16.16, wide enough to hold exactly one
  localparam logic [16:0] ONE_FIX = 17'h1_0000;

  // quotient bits produced by the reciprocal divider (2^32 has 33 bits)
  localparam logic [5:0] DIV_STEPS = 6'd33;

  // operation that the sequencer hands to every lane
  typedef enum logic [1:0] {
    LANE_HOLD,
    LANE_LOAD,
    LANE_MULACC,
    LANE_STEP
  } lane_op_t;

  // control bundle from sequencer to lanes
  typedef struct packed {
    lane_op_t    op;
    logic        zero_acc;
    logic [31:0] coef;
  } lane_ctrl_t;

  // 16.16 multiply: full signed product, bits 47..16 kept (floor, wraps)
  function automatic logic [31:0] fx_mul(input logic signed [31:0] a,
                                         input logic signed [31:0] b);
    logic signed [63:0] p;
    p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
    return p[47:16];
  endfunction

endpackage

@@ src/thrust_drag_velocity_integrator.sv @@
// thrust_drag_velocity_integrator: top level, sequencer, drag product and output stage
// depends on tdvi_pkg, tdvi_div and tdvi_lane
//
// Usage:
//   One input transaction carries an object's velocity, thrust, mass, drag,
//   thrust flag (in_tuser) and frame time; one output transaction returns
//   the new velocity. Three lanes, one per component, share a sequencer and
//   each own a 32x32 multiplier; the output register merges their results.
//   Steps from input to output valid, with n whole steps
//   (n = min(frame_time >> STEP_SHIFT, MAX_WHOLE_STEPS)):
//     zero drag:        prepare, then done
//     drag only:        n multiplies of the scalar drag product, one by the tail,
//                       then one lane scale by the total
//     thrust and drag:  bit-serial reciprocal divider, then one lane multiply per step
//   One item is in flight at a time: with a ready receiver the next item is
//   taken in the cycle after the result registers;
//   in_tready is high while the sequencer is idle, and a new item is taken
//   while the previous result still waits in the output register. If the
//   receiver stalls, the result holds in the output register and the
//   sequencer waits in its last state until the register frees.
//   Reset empties the output register and idles the sequencer.
module thrust_drag_velocity_integrator import tdvi_pkg::*; #(
  parameter int unsigned MAX_WHOLE_STEPS = 64,
  parameter int unsigned STEP_SHIFT      = 10
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // vel_x[31:0] vel_y[63:32] vel_z[95:64] thrust_x[127:96] thrust_y[159:128]
  // thrust_z[191:160] mass[222:192] drag[238:223] frame_time[255:239]
  input  logic [255:0] in_tdata,
  // uses_thrust[0]
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // new_vel_x[31:0] new_vel_y[63:32] new_vel_z[95:64]
  output logic [95:0]  out_tdata
);

  localparam int unsigned CNT_W     = $clog2(MAX_WHOLE_STEPS + 1);
  localparam int unsigned KSH       = 16 - STEP_SHIFT;
  localparam logic [31:0] STEP_MASK = 32'((64'd1 << STEP_SHIFT) - 64'd1);

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PREP  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_ACC   = 4'd3;
  localparam logic [3:0] S_STEP  = 4'd4;
  localparam logic [3:0] S_TAILA = 4'd5;
  localparam logic [3:0] S_TAILB = 4'd6;
  localparam logic [3:0] S_TOT   = 4'd7;
  localparam logic [3:0] S_SCALE = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [15:0]      drag_r;
  logic [16:0]      keep_r;
  logic [15:0]      k_r, k_nxt;
  logic [16:0]      tail_r;
  logic [16:0]      total_r;
  logic             thrust_r;
  logic             out_tvalid_r;
  logic [95:0]      out_tdata_r;

  logic             in_accept;
  logic             out_free;
  logic             cnt_end;
  logic [31:0]      ft_ext;
  logic [31:0]      whole;
  logic [31:0]      kd_prod;
  logic [33:0]      tot_prod;
  logic             div_done;
  logic [31:0]      recip;
  lane_ctrl_t       lane_ctrl;
  logic [31:0]      lane_v [LANES];

  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign cnt_end   = (cnt_r == count_r);

  // split the frame time into whole steps and the remainder fraction
  assign ft_ext    = {15'd0, in_tdata[255:239]};
  assign whole     = ft_ext >> STEP_SHIFT;
  assign count_nxt = (whole > 32'(MAX_WHOLE_STEPS)) ? CNT_W'(MAX_WHOLE_STEPS)
                                                    : CNT_W'(whole);
  assign k_nxt     = 16'((ft_ext & STEP_MASK) << KSH);

  // scalar products: remainder drag share and running drag product
  assign kd_prod  = {16'd0, k_r} * {16'd0, drag_r};
  assign tot_prod = {17'd0, total_r} * {17'd0, (cnt_end ? tail_r : keep_r)};

  // reciprocal of mass, started with every accepted transaction
  tdvi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_accept),
    .mass  (in_tdata[222:192]),
    .done  (div_done),
    .recip (recip)
  );

  // sequencer: next state and lane operation
  always_comb begin
    state_nxt          = state_r;
    lane_ctrl.op       = LANE_HOLD;
    lane_ctrl.zero_acc = !thrust_r;
    lane_ctrl.coef     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt          = S_PREP;
          lane_ctrl.op       = LANE_LOAD;
          lane_ctrl.zero_acc = !in_tuser[0];
        end
      end
      S_PREP: begin
        if (drag_r == 16'd0) begin
          state_nxt = S_DONE;
        end else if (thrust_r) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_TOT;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        lane_ctrl.op   = LANE_MULACC;
        lane_ctrl.coef = recip;
        state_nxt      = S_STEP;
      end
      S_STEP: begin
        if (cnt_end) begin
          state_nxt = S_TAILA;
        end else begin
          lane_ctrl.op   = LANE_STEP;
          lane_ctrl.coef = {15'd0, keep_r};
        end
      end
      S_TAILA: begin
        lane_ctrl.op   = LANE_MULACC;
        lane_ctrl.coef = {16'd0, k_r};
        state_nxt      = S_TAILB;
      end
      S_TAILB: begin
        lane_ctrl.op   = LANE_STEP;
        lane_ctrl.coef = {15'd0, tail_r};
        state_nxt      = S_DONE;
      end
      S_TOT: begin
        if (cnt_end) begin
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        lane_ctrl.op   = LANE_STEP;
        lane_ctrl.coef = {15'd0, total_r};
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_accept) begin
        cnt_r   <= '0;
        count_r <= count_nxt;
      end else if ((state_r == S_STEP || state_r == S_TOT) && !cnt_end) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  // per-item scalar registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      drag_r   <= in_tdata[238:223];
      keep_r   <= ONE_FIX - {1'b0, in_tdata[238:223]};
      k_r      <= k_nxt;
      thrust_r <= in_tuser[0];
    end
    if (state_r == S_PREP) begin
      tail_r  <= ONE_FIX - {1'b0, kd_prod[31:16]};
      total_r <= ONE_FIX;
    end else if (state_r == S_TOT) begin
      total_r <= tot_prod[32:16];
    end
  end

  // component lanes
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    tdvi_lane u_lane (
      .clk       (clk),
      .ctrl      (lane_ctrl),
      .vel_in    (in_tdata[32*i +: 32]),
      .thrust_in (in_tdata[96 + 32*i +: 32]),
      .vel_out   (lane_v[i])
    );
  end

  // output register merges the lane results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_tdata_r <= {lane_v[2], lane_v[1], lane_v[0]};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // step counter never runs past the whole-step count
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= count_r)
    else $error("step counter past whole-step count");

  // an accepted transaction always starts with the prepare state
  a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r == S_PREP)
    else $error("accepted transaction did not enter prepare");

  // sequencer waits for the divider
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && !div_done) |=> state_r == S_DIV)
    else $error("left divide state before reciprocal was ready");

  // finishing an item with a free output slot presents a result
  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> out_tvalid_r)
    else $error("finished item not presented at output");

endmodule

@@ src/tdvi_div.sv @@
// tdvi_div: restoring divider that forms 2^32 / mass, one quotient bit per cycle
// depends on tdvi_pkg for the step count
module tdvi_div import tdvi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [30:0] mass,
  output logic        done,
  output logic [31:0] recip
);

  logic [30:0] mass_r;
  logic [30:0] rem_r;
  logic [32:0] quo_r;
  logic [5:0]  cnt_r;
  logic        run_r;
  logic        done_r;

  logic [31:0] shifted;
  logic [31:0] diff;
  logic        ge;

  // shift in the next dividend bit: a one first, zeros after
  assign shifted = {rem_r, (cnt_r == 6'd0)};
  assign diff    = shifted - {1'b0, mass_r};
  assign ge      = (shifted >= {1'b0, mass_r});

  // control: run for a fixed number of steps, then flag done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + 6'd1;
      if (cnt_r == DIV_STEPS - 6'd1) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // datapath: partial remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      mass_r <= mass;
      rem_r  <= '0;
      quo_r  <= '0;
    end else if (run_r) begin
      rem_r <= ge ? diff[30:0] : shifted[30:0];
      quo_r <= {quo_r[31:0], ge};
    end
  end

  // zero mass gives no acceleration; quotient kept to 32 bits
  assign recip = (mass_r == 31'd0) ? 32'd0 : quo_r[31:0];
  assign done  = done_r;

endmodule

@@ src/tdvi_lane.sv @@
// tdvi_lane: one velocity component with its acceleration register and multiplier
// depends on tdvi_pkg for the lane control bundle and fx_mul
module tdvi_lane import tdvi_pkg::*; (
  input  logic        clk,
  input  lane_ctrl_t  ctrl,
  input  logic [31:0] vel_in,
  input  logic [31:0] thrust_in,
  output logic [31:0] vel_out
);

  logic signed [31:0] v_r;
  logic signed [31:0] acc_r;
  logic signed [31:0] mul_a;
  logic [31:0]        prod;

  // multiplier operand: velocity plus acceleration for a step, else acceleration
  assign mul_a = (ctrl.op == LANE_STEP) ? v_r + acc_r : acc_r;
  assign prod  = fx_mul(mul_a, $signed(ctrl.coef));

  // lane registers
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      LANE_LOAD: begin
        v_r   <= $signed(vel_in);
        acc_r <= ctrl.zero_acc ? 32'sd0 : $signed(thrust_in);
      end
      LANE_MULACC: begin
        acc_r <= $signed(prod);
      end
      LANE_STEP: begin
        v_r <= $signed(prod);
      end
      LANE_HOLD: begin
      end
    endcase
  end

  assign vel_out = v_r;

endmodule

@@ bench/thrust_drag_velocity_integrator_tb.sv @@
// thrust_drag_velocity_integrator_tb: self-checking bench for the velocity integrator
// drives frames over the input stream, predicts each new velocity in 16.16 and
// checks every output transaction; depends on the thrust_drag_velocity_integrator rtl
module thrust_drag_velocity_integrator_tb;

  localparam int unsigned STEP_SHIFT      = 10;
  localparam int unsigned MAX_WHOLE_STEPS = 64;
  localparam int          STALL_LIMIT     = 2000;
  localparam int          DRAIN_CYCLES    = 120;
  localparam logic signed [31:0] FIX_ONE  = 32'sh0001_0000;

  // one frame of object state as it crosses the input stream
  typedef struct packed {
    logic [2:0][31:0] vel;
    logic [2:0][31:0] thrust;
    logic [30:0]      mass;
    logic [15:0]      drag;
    logic             thrust_on;
    logic [16:0]      frame_time;
  } frame_item_t;

  typedef logic [2:0][31:0] vel3_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [255:0] in_tdata = '0;
  logic [0:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [95:0]  out_tdata;

  vel3_t expected_vel[$];
  vel3_t want_vel;
  bit    idle_on = 1'b1;
  int    errors = 0;
  int    n_checked = 0;
  int    n_thrust = 0;
  int    n_drag_only = 0;
  int    n_zero_drag = 0;
  int    quiet_cycles = 0;
  int    stall_left = 0;
  string comp_name[3] = '{"new_vel_x", "new_vel_y", "new_vel_z"};

  thrust_drag_velocity_integrator #(
    .MAX_WHOLE_STEPS(MAX_WHOLE_STEPS),
    .STEP_SHIFT     (STEP_SHIFT)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  // 16.16 product, floor of the 64-bit product, wrapped to 32 bits
  function automatic logic signed [31:0] q16_mul(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    logic signed [63:0] full;
    full = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
    return full[47:16];
  endfunction

  // new velocity after one frame of thrust and drag
  function automatic vel3_t predict_velocity(input frame_item_t it);
    logic signed [31:0] v[3];
    logic signed [31:0] accel[3];
    logic signed [31:0] frac_k, keep, tail, recip, total;
    logic [63:0]        quotient;
    int unsigned        steps;
    vel3_t              res;
    for (int j = 0; j < 3; j++) begin
      v[j] = it.vel[j];
    end
    if (it.drag != 16'd0) begin
      steps = 32'(it.frame_time) >> STEP_SHIFT;
      if (steps > MAX_WHOLE_STEPS) steps = MAX_WHOLE_STEPS;
      frac_k = 32'(it.frame_time[STEP_SHIFT-1:0]) << (16 - STEP_SHIFT);
      keep   = FIX_ONE - $signed({16'd0, it.drag});
      tail   = FIX_ONE - q16_mul(frac_k, $signed({16'd0, it.drag}));
      if (it.thrust_on) begin
        // reciprocal of mass as a signed 32-bit value, zero for zero mass
        recip = '0;
        if (it.mass != '0) begin
          quotient = 64'h1_0000_0000 / {33'd0, it.mass};
          recip    = quotient[31:0];
        end
        for (int j = 0; j < 3; j++) accel[j] = q16_mul(it.thrust[j], recip);
        for (int unsigned s = 0; s < steps; s++) begin
          for (int j = 0; j < 3; j++) v[j] = q16_mul(v[j] + accel[j], keep);
        end
        for (int j = 0; j < 3; j++) begin
          v[j] = v[j] + q16_mul(accel[j], frac_k);
          v[j] = q16_mul(v[j], tail);
        end
      end else begin
        // drag only: one combined factor
        total = FIX_ONE;
        for (int unsigned s = 0; s < steps; s++) total = q16_mul(total, keep);
        total = q16_mul(total, tail);
        for (int j = 0; j < 3; j++) v[j] = q16_mul(v[j], total);
      end
    end
    for (int j = 0; j < 3; j++) res[j] = v[j];
    return res;
  endfunction

  // frame with three related components derived from one seed value
  function automatic frame_item_t make_frame(input logic [31:0] v, input logic [31:0] t,
                                             input logic [30:0] mass, input logic [15:0] drag,
                                             input logic on, input logic [16:0] ft);
    frame_item_t it;
    it.vel        = {v + 32'h0003_2000, ~v, v};
    it.thrust     = {t - 32'h0001_8000, ~t, t};
    it.mass       = mass;
    it.drag       = drag;
    it.thrust_on  = on;
    it.frame_time = ft;
    return it;
  endfunction

  function automatic logic [31:0] random_vector_word();
    if ($urandom_range(0, 3) == 0) return $urandom();
    return 32'($signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000);
  endfunction

  // random frame: mostly realistic values, some full-range noise
  function automatic frame_item_t random_frame();
    frame_item_t it;
    for (int j = 0; j < 3; j++) begin
      it.vel[j]    = random_vector_word();
      it.thrust[j] = random_vector_word();
    end
    case ($urandom_range(0, 7))
      0:       it.mass = ($urandom_range(0, 63) == 0) ? 31'd0 : 31'($urandom());
      1:       it.mass = 31'($urandom_range(1, 32'h0000_FFFF));
      2:       it.mass = 31'($urandom_range(1, 16));
      default: it.mass = 31'($urandom_range(32'h0001_0000, 32'h00FF_FFFF));
    endcase
    case ($urandom_range(0, 9))
      0:       it.drag = '0;
      1, 2:    it.drag = 16'($urandom());
      default: it.drag = 16'($urandom_range(1, 16'h2000));
    endcase
    case ($urandom_range(0, 31))
      0:             it.frame_time = '0;
      1, 2, 3, 4:    it.frame_time = 17'($urandom_range(17'h1_0001, 17'h1_FFFF));
      default:       it.frame_time = 17'($urandom_range(1, 17'h1_0000));
    endcase
    it.thrust_on = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // one input transaction, with an optional idle burst ahead of it
  task automatic send_item(input frame_item_t it);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {it.frame_time, it.drag, it.mass, it.thrust, it.vel};
    in_tuser  <= it.thrust_on;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_vel.push_back(predict_velocity(it));
    if (it.drag == '0) n_zero_drag++;
    else if (it.thrust_on) n_thrust++;
    else n_drag_only++;
  endtask

  // zero drag passes the velocity through in both modes
  task automatic test_zero_drag();
    send_item(make_frame(32'h0012_3456, 32'h0100_0000, 31'h1_0000, 16'd0, 1'b1, 17'h0_4000));
    send_item(make_frame(32'hFFF0_0001, 32'h0100_0000, 31'h1_0000, 16'd0, 1'b0, 17'h1_0000));
    send_item(make_frame(32'h7FFF_FFFF, 32'h8000_0000, 31'd1, 16'd0, 1'b1, 17'h1_FFFF));
  endtask

  // zero frame time, remainder only, and exactly one whole step
  task automatic test_short_frames();
    send_item(make_frame(32'h0004_8000, 32'h0020_0000, 31'h2_0000, 16'h0800, 1'b0, 17'd0));
    send_item(make_frame(32'h0004_8000, 32'h0020_0000, 31'h2_0000, 16'h0800, 1'b1, 17'd0));
    send_item(make_frame(32'hFFFC_0000, 32'h0020_0000, 31'h2_0000, 16'h0800, 1'b1, 17'd1));
    send_item(make_frame(32'h0010_0000, 32'hFFE0_0000, 31'h2_0000, 16'h0800, 1'b1, 17'd1023));
    send_item(make_frame(32'h0010_0000, 32'h0020_0000, 31'h2_0000, 16'h0800, 1'b0, 17'd1024));
    send_item(make_frame(32'h0010_0000, 32'h0020_0000, 31'h2_0000, 16'h0800, 1'b1, 17'd1024));
  endtask

  // full second and frames that saturate the whole-step count
  task automatic test_long_frames();
    send_item(make_frame(32'h0100_0000, 32'h0040_0000, 31'h1_8000, 16'h0400, 1'b1, 17'h1_0000));
    send_item(make_frame(32'h0100_0000, 32'h0040_0000, 31'h1_8000, 16'h0400, 1'b0, 17'h1_0000));
    send_item(make_frame(32'h0100_0000, 32'h0040_0000, 31'h1_8000, 16'h0400, 1'b1, 17'h1_FFFF));
    send_item(make_frame(32'h0100_0000, 32'h0040_0000, 31'h1_8000, 16'h0400, 1'b0, 17'h1_FFFF));
    send_item(make_frame(32'h0100_0000, 32'h0040_0000, 31'h1_8000, 16'hFFFF, 1'b1, 17'h1_0000));
  endtask

  // reciprocal corner cases: zero, one, two and the largest mass
  task automatic test_mass_cases();
    send_item(make_frame(32'h0002_0000, 32'h0050_0000, 31'd0, 16'h1000, 1'b1, 17'h0_8000));
    send_item(make_frame(32'h0002_0000, 32'h0050_0000, 31'd1, 16'h1000, 1'b1, 17'h0_8000));
    send_item(make_frame(32'h0002_0000, 32'h0050_0000, 31'd2, 16'h1000, 1'b1, 17'h0_8000));
    send_item(make_frame(32'h0002_0000, 32'h0050_0000, 31'h7FFF_FFFF, 16'h1000, 1'b1,
                         17'h0_8000));
  endtask

  // field extremes with wrapping sums and products
  task automatic test_field_extremes();
    send_item(make_frame(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h0000_4000, 16'd1, 1'b1, 17'h1_0000));
    send_item(make_frame(32'h8000_0000, 32'h8000_0000, 31'h0000_4000, 16'd1, 1'b0, 17'h1_0000));
    send_item(make_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF, 1'b1,
                         17'h1_FFFF));
    send_item(make_frame(32'h0000_0000, 32'h0000_0000, 31'h7FFF_FFFF, 16'hFFFF, 1'b0,
                         17'h1_FFFF));
  endtask

  task automatic test_random_traffic(input int count);
    for (int i = 0; i < count; i++) send_item(random_frame());
  endtask

  // back-to-back traffic with both sides always ready
  task automatic test_full_rate(input int count);
    idle_on = 1'b0;
    for (int i = 0; i < count; i++) send_item(random_frame());
  endtask

  // receiver: random stall bursts while idling is on
  always @(posedge clk) begin
    if (!idle_on) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(1, 5) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result checker: compare each output transaction with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_vel.size() == 0) begin
        $error("output transaction with no frame pending: %h", out_tdata);
        errors++;
      end else begin
        want_vel = expected_vel.pop_front();
        n_checked++;
        for (int j = 0; j < 3; j++) begin
          if (out_tdata[32*j +: 32] !== want_vel[j]) begin
            $error("%s expected %0d actual %0d", comp_name[j], $signed(want_vel[j]),
                   $signed(out_tdata[32*j +: 32]));
            errors++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // test sequence
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero_drag();
    test_short_frames();
    test_long_frames();
    test_mass_cases();
    test_field_extremes();
    test_random_traffic(1130);
    test_full_rate(300);
    in_tvalid <= 1'b0;
    while (expected_vel.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("frames sent: %0d thrust, %0d drag only, %0d zero drag", n_thrust, n_drag_only,
             n_zero_drag);
    $display("velocities checked: %0d, mismatches: %0d", n_checked, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
